// File: rtl/qrpt_pkg.sv
// Shared types, constants and helpers for the quaternion point transform
`timescale 1ns / 1ps

package qrpt_pkg;

  localparam int COORD_W    = 24;
  localparam int QUAT_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_STAGES = 6;

  // products and coefficients
  localparam int PROD_W  = 2 * QUAT_W;       // 36
  localparam int COEF_W  = PROD_W + 2;       // 38
  localparam int SPLIT   = 19;               // low part of a coefficient
  localparam int HI_W    = COEF_W - SPLIT;   // 19
  localparam int PHI_W   = HI_W + COORD_W;   // 43
  localparam int PLO_W   = SPLIT + 1 + COORD_W; // 44
  localparam int SHI_W   = PHI_W + 2;        // 45
  localparam int SLO_W   = PLO_W + 2;        // 46
  localparam int ACC_W   = 64;
  localparam int ROT_V_W = 32;
  localparam int WIDE_W  = 33;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROT_W       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_USE_INVERSE = 3'd7;

  localparam logic signed [QUAT_W-1:0] ROT_W_RESET = 18'sd65536;

  localparam logic signed [WIDE_W-1:0] COORD_MAX = 33'sd8388607;
  localparam logic signed [WIDE_W-1:0] COORD_MIN = -33'sd8388608;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] val;
  } sat_t;

  // clamp a wide signed value to the coordinate range
  function automatic sat_t sat_coord(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > COORD_MAX) begin
      r.hit = 1'b1;
      r.val = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r.hit = 1'b1;
      r.val = COORD_MIN[COORD_W-1:0];
    end else begin
      r.hit = 1'b0;
      r.val = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/qrpt_in_if.sv
// Point request channel: valid/ready with the three input coordinates
`timescale 1ns / 1ps

interface qrpt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qrpt_pkg::COORD_W-1:0]  point_x;
  logic signed [qrpt_pkg::COORD_W-1:0]  point_y;
  logic signed [qrpt_pkg::COORD_W-1:0]  point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

// File: rtl/qrpt_out_if.sv
// Result channel: valid/ready with the transformed point and clip flag
`timescale 1ns / 1ps

interface qrpt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qrpt_pkg::COORD_W-1:0]  out_x;
  logic signed [qrpt_pkg::COORD_W-1:0]  out_y;
  logic signed [qrpt_pkg::COORD_W-1:0]  out_z;
  logic                                 clipped;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output clipped, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input clipped, output ready);
endinterface

// File: rtl/quaternion_rigid_point_transform.sv
// Quaternion rigid transform of a point stream, six-stage pipeline
//
//   channel   direction  handshake          payload
//   in_pt     in         valid/ready        point_x, point_y, point_z
//   out_res   out        valid/ready        out_x, out_y, out_z, clipped
//   cfg       in         cfg_we, no ready   cfg_idx, cfg_wdata
//
// One point per cycle while results are taken; a request accepted into the first stage
// passes through the six register stages (products, coefficients, partial products,
// row sums, rounding, translation and clamp) to the result register.
// Reset is synchronous: the configuration registers return to the identity transform,
// the pipeline empties. A stalled stage holds its data; bubbles behind it still close
// up, so requests keep entering while a result waits, until every stage is full.
`timescale 1ns / 1ps

module quaternion_rigid_point_transform (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [qrpt_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [qrpt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  qrpt_in_if.sink                              in_pt,
  qrpt_out_if.source                           out_res
);

  localparam int CW = qrpt_pkg::COORD_W;
  localparam int NS = qrpt_pkg::NUM_STAGES;

  // configuration registers
  logic signed [qrpt_pkg::QUAT_W-1:0] rot_w_r, rot_x_r, rot_y_r, rot_z_r;
  logic signed [CW-1:0]               shift_r [3];
  logic                               use_inverse_r;

  // pipeline control
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] adv;
  logic          in_acc;

  // stage 1: quaternion products and the point
  logic signed [qrpt_pkg::PROD_W-1:0] s1_ww_r, s1_xx_r, s1_yy_r, s1_zz_r;
  logic signed [qrpt_pkg::PROD_W-1:0] s1_xy_r, s1_xz_r, s1_yz_r;
  logic signed [qrpt_pkg::PROD_W-1:0] s1_wx_r, s1_wy_r, s1_wz_r;
  logic signed [CW-1:0]               s1_p_r [3];
  logic signed [CW-1:0]               s1_p_nxt [3];
  logic                               s1_clip_r, s1_clip_nxt;

  // stage 2: rotation coefficients, row major
  logic signed [qrpt_pkg::COEF_W-1:0] s2_coef_r [9];
  logic signed [qrpt_pkg::COEF_W-1:0] s2_coef_nxt [9];
  logic signed [CW-1:0]               s2_p_r [3];
  logic                               s2_clip_r;

  // stage 3: split partial products
  logic signed [qrpt_pkg::PHI_W-1:0]  s3_hi_r [9];
  logic signed [qrpt_pkg::PHI_W-1:0]  s3_hi_nxt [9];
  logic signed [qrpt_pkg::PLO_W-1:0]  s3_lo_r [9];
  logic signed [qrpt_pkg::PLO_W-1:0]  s3_lo_nxt [9];
  logic                               s3_clip_r;

  // stage 4: row sums of the partial products
  logic signed [qrpt_pkg::SHI_W-1:0]  s4_hi_r [3];
  logic signed [qrpt_pkg::SHI_W-1:0]  s4_hi_nxt [3];
  logic signed [qrpt_pkg::SLO_W-1:0]  s4_lo_r [3];
  logic signed [qrpt_pkg::SLO_W-1:0]  s4_lo_nxt [3];
  logic                               s4_clip_r;

  // stage 5: rounded rotated coordinates
  logic signed [qrpt_pkg::ROT_V_W-1:0] s5_v_r [3];
  logic signed [qrpt_pkg::ROT_V_W-1:0] s5_v_nxt [3];
  logic                                s5_clip_r;

  // stage 6: result register
  logic signed [CW-1:0]               s6_o_r [3];
  logic signed [CW-1:0]               s6_o_nxt [3];
  logic                               s6_clip_r, s6_clip_nxt;

  logic signed [CW-1:0]               pt_in [3];

  assign pt_in[0] = in_pt.point_x;
  assign pt_in[1] = in_pt.point_y;
  assign pt_in[2] = in_pt.point_z;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_w_r       <= qrpt_pkg::ROT_W_RESET;
      rot_x_r       <= '0;
      rot_y_r       <= '0;
      rot_z_r       <= '0;
      shift_r[0]    <= '0;
      shift_r[1]    <= '0;
      shift_r[2]    <= '0;
      use_inverse_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        qrpt_pkg::REG_ROT_W:       rot_w_r       <= cfg_wdata[qrpt_pkg::QUAT_W-1:0];
        qrpt_pkg::REG_ROT_X:       rot_x_r       <= cfg_wdata[qrpt_pkg::QUAT_W-1:0];
        qrpt_pkg::REG_ROT_Y:       rot_y_r       <= cfg_wdata[qrpt_pkg::QUAT_W-1:0];
        qrpt_pkg::REG_ROT_Z:       rot_z_r       <= cfg_wdata[qrpt_pkg::QUAT_W-1:0];
        qrpt_pkg::REG_SHIFT_X:     shift_r[0]    <= cfg_wdata[CW-1:0];
        qrpt_pkg::REG_SHIFT_Y:     shift_r[1]    <= cfg_wdata[CW-1:0];
        qrpt_pkg::REG_SHIFT_Z:     shift_r[2]    <= cfg_wdata[CW-1:0];
        qrpt_pkg::REG_USE_INVERSE: use_inverse_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------------- handshake
  // A stage moves on when it is empty or the stage after it moves on.
  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_res.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_pt.ready = adv[0];
  assign in_acc      = in_pt.valid && adv[0];

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) vld_nxt[0] = in_pt.valid;
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // --------------------------------------------------------------- stage 1
  always_comb begin
    qrpt_pkg::sat_t d;
    s1_clip_nxt = 1'b0;
    for (int j = 0; j < 3; j++) begin
      d = qrpt_pkg::sat_coord(qrpt_pkg::WIDE_W'(pt_in[j])
                              - qrpt_pkg::WIDE_W'(shift_r[j]));
      if (use_inverse_r) begin
        s1_p_nxt[j] = d.val;
        s1_clip_nxt = s1_clip_nxt | d.hit;
      end else begin
        s1_p_nxt[j] = pt_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_ww_r   <= rot_w_r * rot_w_r;
      s1_xx_r   <= rot_x_r * rot_x_r;
      s1_yy_r   <= rot_y_r * rot_y_r;
      s1_zz_r   <= rot_z_r * rot_z_r;
      s1_xy_r   <= rot_x_r * rot_y_r;
      s1_xz_r   <= rot_x_r * rot_z_r;
      s1_yz_r   <= rot_y_r * rot_z_r;
      s1_wx_r   <= rot_w_r * rot_x_r;
      s1_wy_r   <= rot_w_r * rot_y_r;
      s1_wz_r   <= rot_w_r * rot_z_r;
      s1_p_r    <= s1_p_nxt;
      s1_clip_r <= s1_clip_nxt;
    end
  end

  // --------------------------------------------------------------- stage 2
  always_comb begin
    logic signed [qrpt_pkg::COEF_W-1:0] ww, xx, yy, zz, xy, xz, yz, swx, swy, swz;
    ww  = qrpt_pkg::COEF_W'(s1_ww_r);
    xx  = qrpt_pkg::COEF_W'(s1_xx_r);
    yy  = qrpt_pkg::COEF_W'(s1_yy_r);
    zz  = qrpt_pkg::COEF_W'(s1_zz_r);
    xy  = qrpt_pkg::COEF_W'(s1_xy_r);
    xz  = qrpt_pkg::COEF_W'(s1_xz_r);
    yz  = qrpt_pkg::COEF_W'(s1_yz_r);
    swx = qrpt_pkg::COEF_W'(s1_wx_r);
    swy = qrpt_pkg::COEF_W'(s1_wy_r);
    swz = qrpt_pkg::COEF_W'(s1_wz_r);
    // the inverse flips the sense of the cross-product terms
    if (use_inverse_r) begin
      swx = -swx;
      swy = -swy;
      swz = -swz;
    end
    s2_coef_nxt[0] = ww + xx - yy - zz;
    s2_coef_nxt[1] = (xy - swz) <<< 1;
    s2_coef_nxt[2] = (xz + swy) <<< 1;
    s2_coef_nxt[3] = (xy + swz) <<< 1;
    s2_coef_nxt[4] = ww - xx + yy - zz;
    s2_coef_nxt[5] = (yz - swx) <<< 1;
    s2_coef_nxt[6] = (xz - swy) <<< 1;
    s2_coef_nxt[7] = (yz + swx) <<< 1;
    s2_coef_nxt[8] = ww - xx - yy + zz;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_coef_r <= s2_coef_nxt;
      s2_p_r    <= s1_p_r;
      s2_clip_r <= s1_clip_r;
    end
  end

  // --------------------------------------------------------------- stage 3
  // Split each coefficient so no multiplier exceeds 20 x 24 bits.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      s3_hi_nxt[k] = $signed(s2_coef_r[k][qrpt_pkg::COEF_W-1:qrpt_pkg::SPLIT])
                     * s2_p_r[k % 3];
      s3_lo_nxt[k] = $signed({1'b0, s2_coef_r[k][qrpt_pkg::SPLIT-1:0]})
                     * s2_p_r[k % 3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_hi_r   <= s3_hi_nxt;
      s3_lo_r   <= s3_lo_nxt;
      s3_clip_r <= s2_clip_r;
    end
  end

  // --------------------------------------------------------------- stage 4
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_hi_nxt[i] = qrpt_pkg::SHI_W'(s3_hi_r[3*i])
                   + qrpt_pkg::SHI_W'(s3_hi_r[3*i+1])
                   + qrpt_pkg::SHI_W'(s3_hi_r[3*i+2]);
      s4_lo_nxt[i] = qrpt_pkg::SLO_W'(s3_lo_r[3*i])
                   + qrpt_pkg::SLO_W'(s3_lo_r[3*i+1])
                   + qrpt_pkg::SLO_W'(s3_lo_r[3*i+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_hi_r   <= s4_hi_nxt;
      s4_lo_r   <= s4_lo_nxt;
      s4_clip_r <= s3_clip_r;
    end
  end

  // --------------------------------------------------------------- stage 5
  // Recombine, add half an LSB and take the floor of the top word.
  always_comb begin
    logic signed [qrpt_pkg::ACC_W-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = (qrpt_pkg::ACC_W'(s4_hi_r[i]) <<< qrpt_pkg::SPLIT)
          + qrpt_pkg::ACC_W'(s4_lo_r[i])
          + 64'sd2147483648;
      s5_v_nxt[i] = acc[qrpt_pkg::ACC_W-1:qrpt_pkg::ACC_W-qrpt_pkg::ROT_V_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_v_r    <= s5_v_nxt;
      s5_clip_r <= s4_clip_r;
    end
  end

  // --------------------------------------------------------------- stage 6
  always_comb begin
    qrpt_pkg::sat_t r;
    logic signed [qrpt_pkg::WIDE_W-1:0] t;
    s6_clip_nxt = s5_clip_r;
    for (int i = 0; i < 3; i++) begin
      t = use_inverse_r ? '0 : qrpt_pkg::WIDE_W'(shift_r[i]);
      r = qrpt_pkg::sat_coord(qrpt_pkg::WIDE_W'(s5_v_r[i]) + t);
      s6_o_nxt[i] = r.val;
      s6_clip_nxt = s6_clip_nxt | r.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_o_r    <= s6_o_nxt;
      s6_clip_r <= s6_clip_nxt;
    end
  end

  assign out_res.valid   = vld_r[NS-1];
  assign out_res.out_x   = s6_o_r[0];
  assign out_res.out_y   = s6_o_r[1];
  assign out_res.out_z   = s6_o_r[2];
  assign out_res.clipped = s6_clip_r;

`ifndef NO_ASSERTIONS
  // an empty pipeline with nothing entering cannot show a result next cycle
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r == '0 && !in_acc) |=> !out_res.valid)
    else $error("result appeared from an empty pipeline");

  // a full first stage that cannot advance keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !adv[0]) |=> (vld_r[0] && $stable(s1_p_r[0])
                               && $stable(s1_p_r[1]) && $stable(s1_p_r[2])))
    else $error("stalled first stage lost or changed its request");

  // a completely full, stalled pipeline must refuse new requests
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r && !out_res.ready) |-> !in_pt.ready)
    else $error("request accepted into a full stalled pipeline");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.ready && !vld_r[NS-2]) |=> !out_res.valid)
    else $error("result repeated after it was taken");
`endif

endmodule
